// ----- design/smpq_pkg.sv -----
// Package for the sorted minimum priority queue.
// Sizes, command and status codes, and the cell control struct.
// No dependencies; every other design file imports it.
`default_nettype none

package smpq_pkg;

  // Queue depth and derived widths
  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int REP_W  = 7;   // width of reported counts
  localparam int TOT_W  = 32;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Broadcast control to every cell of the chain
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/smpq_if.sv -----
// Request channel interfaces for the sorted minimum priority queue.
// Depends on smpq_pkg for field widths.
`default_nettype none

interface smpq_in_if import smpq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface smpq_out_if import smpq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] removed_value;
  logic                     removed_valid;
  logic [REP_W-1:0]         insert_checks;
  logic [TOT_W-1:0]         total_checks;
  logic [REP_W-1:0]         entry_count;
  logic [1:0]               status;

  modport source (output valid, removed_value, removed_valid, insert_checks,
                  total_checks, entry_count, status, input ready);
  modport sink   (input valid, removed_value, removed_valid, insert_checks,
                  total_checks, entry_count, status, output ready);
endinterface

`default_nettype wire

// ----- design/smpq_cell.sv -----
// One storage cell of the sorted queue: a value, a valid bit and a comparator.
// Depends on smpq_pkg.
`default_nettype none

module smpq_cell import smpq_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cell_ctl_t                ctl,
  input  wire logic signed [DATA_W-1:0] left_val,
  input  wire logic                     left_valid,
  input  wire logic                     left_flag,
  input  wire logic signed [DATA_W-1:0] right_val,
  input  wire logic                     right_valid,
  output logic signed [DATA_W-1:0]      val_o,
  output logic                          valid_o,
  output logic                          flag_o
);

  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     valid_r, valid_nxt;

  // Flag marks the cells at or after the insert point (monotone along the row)
  assign flag_o  = !valid_r || (val_r >= ctl.value);
  assign val_o   = val_r;
  assign valid_o = valid_r;

  // Insert: boundary cell takes the new value, later cells take the left one.
  // Remove: every cell takes its right neighbor.
  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctl.ins) begin
      if (flag_o && !left_flag) begin
        val_nxt   = ctl.value;
        valid_nxt = 1'b1;
      end else if (flag_o) begin
        val_nxt   = left_val;
        valid_nxt = left_valid;
      end
    end else if (ctl.rem) begin
      val_nxt   = right_val;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/smpq_chain.sv -----
// Row of DEPTH cells forming the sorted store, plus the insert-point encoder.
// Depends on smpq_pkg and smpq_cell.
`default_nettype none

module smpq_chain import smpq_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cell_ctl_t           ctl,
  output logic signed [DATA_W-1:0] head_val,
  output logic [IDX_W-1:0]         ins_pos,
  output logic [DEPTH-1:0]         valid_vec
);

  logic signed [DATA_W-1:0] vals  [DEPTH];
  logic [DEPTH-1:0]         flags;
  logic [DEPTH-1:0]         bound;

  // Cell row; cell 0 sees a valid, below-everything left side, last cell an empty right side
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] lv, rv;
    logic                     lvld, lflg, rvld;

    if (i == 0) begin : g_first
      assign lv   = '0;
      assign lvld = 1'b1;
      assign lflg = 1'b0;
    end else begin : g_mid_l
      assign lv   = vals[i-1];
      assign lvld = valid_vec[i-1];
      assign lflg = flags[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv   = '0;
      assign rvld = 1'b0;
    end else begin : g_mid_r
      assign rv   = vals[i+1];
      assign rvld = valid_vec[i+1];
    end

    smpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_val    (lv),
      .left_valid  (lvld),
      .left_flag   (lflg),
      .right_val   (rv),
      .right_valid (rvld),
      .val_o       (vals[i]),
      .valid_o     (valid_vec[i]),
      .flag_o      (flags[i])
    );

    assign bound[i] = flags[i] && !lflg;
  end

  assign head_val = vals[0];

  // One-hot boundary to index: OR of the indexes of set bits
  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ins_pos = ins_pos | (IDX_W'(i) & {IDX_W{bound[i]}});
    end
  end

endmodule

`default_nettype wire

// ----- design/sorted_min_priority_queue.sv -----
// Top level of the sorted minimum priority queue: request handshakes,
// counters and the result register. Depends on smpq_pkg, smpq_if, smpq_chain.
//
//  channel | dir | fields
//  in_ch   | in  | cmd, value
//  out_ch  | out | removed_value, removed_valid, insert_checks, total_checks,
//          |     | entry_count, status
//
// Each request is first captured; then all cells compare against the value
// in parallel and shift together in the update cycle.
// The update cycle waits while the result register is full and not taken.
// A new request is taken while a finished result still waits downstream.
// Reset (synchronous, rst_n low) empties the queue and clears the total.
`default_nettype none

module sorted_min_priority_queue import smpq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  smpq_in_if.sink     in_ch,
  smpq_out_if.source  out_ch
);

  // Captured request
  logic                     busy_r;
  logic                     cmd_r;
  logic signed [DATA_W-1:0] value_r;

  // Queue bookkeeping
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;

  // Result register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] rem_val_r;
  logic                     rem_vld_r;
  logic [REP_W-1:0]         checks_r;
  status_t                  status_r, status_nxt;

  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] head_val;
  logic [IDX_W-1:0]         ins_pos;
  logic [DEPTH-1:0]         valid_vec;
  logic                     go, full, empty;
  logic [CNT_W-1:0]         pos_ext, checks;
  logic [TOT_W:0]           sum;

  assign in_ch.ready = !busy_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign go    = busy_r && (!out_valid_r || out_ch.ready);

  assign ctl.ins   = go && (cmd_r == CMD_INSERT) && !full;
  assign ctl.rem   = go && (cmd_r == CMD_REMOVE) && !empty;
  assign ctl.value = value_r;

  smpq_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .head_val  (head_val),
    .ins_pos   (ins_pos),
    .valid_vec (valid_vec)
  );

  // Comparisons: position plus one, or the length on an append
  assign pos_ext = CNT_W'(ins_pos);
  assign checks  = (pos_ext < count_r) ? pos_ext + CNT_W'(1) : count_r;
  assign sum     = {1'b0, total_r} + (TOT_W + 1)'(checks);

  always_comb begin
    count_nxt  = count_r;
    total_nxt  = total_r;
    status_nxt = ST_OK;
    if (cmd_r == CMD_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        total_nxt = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      total_r     <= '0;
    end else begin
      // Capture a request
      if (in_ch.valid && in_ch.ready) begin
        busy_r  <= 1'b1;
        cmd_r   <= in_ch.cmd;
        value_r <= in_ch.value;
      end
      // Update the chain and load the result
      if (go) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        count_r     <= count_nxt;
        total_r     <= total_nxt;
        status_r    <= status_nxt;
        rem_vld_r   <= ctl.rem;
        rem_val_r   <= ctl.rem ? head_val : '0;
        checks_r    <= ctl.ins ? REP_W'(checks) : '0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = rem_val_r;
  assign out_ch.removed_valid = rem_vld_r;
  assign out_ch.insert_checks = checks_r;
  assign out_ch.total_checks  = total_r;
  assign out_ch.entry_count   = REP_W'(count_r);
  assign out_ch.status        = status_r;

`ifndef SYNTHESIS
  // Count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // Head cell holds data exactly when the queue is not empty
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_vec[0] == (count_r != '0))
    else $error("head cell valid disagrees with count");

  // A pending request waits while the result register is blocked
  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_valid_r && !out_ch.ready |=> busy_r)
    else $error("request processed into a blocked result register");

  // A removed value only comes with an ok status
  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rem_vld_r |-> status_r == ST_OK)
    else $error("removed value with error status");
`endif

endmodule

`default_nettype wire
